FILE: rtl/escr_pkg.sv
package escr_pkg;

	// Item kinds carried on func
	typedef enum logic [1:0] {
		FUNC_EDGE_A = 2'd0,
		FUNC_EDGE_B = 2'd1,
		FUNC_SAMPLE = 2'd2
	} func_t;

	// Encoder event handed to the setpoint tracker
	typedef struct packed {
		logic edge_a;
		logic edge_b;
		logic line_a;
		logic line_b;
	} enc_evt_t;

	localparam int SP_BITS = 6;
	localparam logic [SP_BITS-1:0] LIMIT_RST = 6'd10;

	// Error is kept in tenths: setpoint*1000 -> *10000, sample*2.2 -> *22
	localparam int TGT_SCALE = 10000;
	localparam int ADC_SCALE = 22;

	// Band thresholds in tenths per amp of setpoint and their code steps,
	// widest band first
	localparam int NUM_BANDS = 6;
	localparam int BAND_K [NUM_BANDS] = '{8000, 6000, 4000, 3000, 2000, 1000};
	localparam int BAND_STEP [NUM_BANDS] = '{300, 170, 120, 60, 40, 30};

endpackage

FILE: rtl/encoder_set_current_regulator_unit.sv
// Banded-step current regulator with encoder-driven amp setpoint.
// An accepted beat waits in the input stage until the result state is free, then
// is processed into it. Throughput: one item per cycle while out_stall is low,
// bounded by the single error/band/step pass.
// Reset (arst_n low, asynchronous): flags, setpoint and DAC code clear, the
// setpoint limit returns to 10, and both pipeline stages empty.
module encoder_set_current_regulator_unit #(
	parameter int DAC_BITS = 12,
	parameter int ADC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   func,
	input  logic                         line_a,
	input  logic                         line_b,
	input  logic signed [ADC_BITS-1:0]   sample,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [DAC_BITS-1:0]          dac_code,
	output logic [escr_pkg::SP_BITS-1:0] setpoint_amps,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [escr_pkg::SP_BITS-1:0] cfg_data
);

	logic                         valid_s1;
	logic [1:0]                   func_s1;
	logic                         line_a_s1;
	logic                         line_b_s1;
	logic signed [ADC_BITS-1:0]   sample_s1;
	logic                         out_valid_q;
	logic [escr_pkg::SP_BITS-1:0] limit_q;
	logic                         advance;
	logic                         process;
	escr_pkg::enc_evt_t           evt;
	logic                         sample_en;

	// Result state doubles as the output register: move only when it is free
	assign advance  = !out_valid_q || !out_stall;
	assign process  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	// Capture input beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1   <= func;
			line_a_s1 <= line_a;
			line_b_s1 <= line_b;
			sample_s1 <= sample;
		end
	end

	// Hold the result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (process) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Setpoint limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= escr_pkg::LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// Decode the item kind
	always_comb begin
		evt.edge_a = process && (func_s1 == escr_pkg::FUNC_EDGE_A);
		evt.edge_b = process && (func_s1 == escr_pkg::FUNC_EDGE_B);
		evt.line_a = line_a_s1;
		evt.line_b = line_b_s1;
		sample_en  = process && (func_s1 == escr_pkg::FUNC_SAMPLE);
	end

	escr_encoder u_encoder (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.limit    (limit_q),
		.setpoint (setpoint_amps)
	);

	escr_regulator #(
		.DAC_BITS (DAC_BITS),
		.ADC_BITS (ADC_BITS)
	) u_regulator (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (sample_en),
		.setpoint (setpoint_amps),
		.sample   (sample_s1),
		.dac_code (dac_code)
	);

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	// A processed item always shows up as a result
	a_process_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		process |=> out_valid)
		else $error("processed item did not produce a result");

	// Only ADC samples move the DAC code
	a_code_only_on_sample: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_en |=> $stable(dac_code))
		else $error("DAC code changed without a sample");

	// The setpoint moves by at most one amp per cycle
	a_setpoint_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (setpoint_amps == $past(setpoint_amps)
			|| setpoint_amps == $past(setpoint_amps) + 6'd1
			|| setpoint_amps == $past(setpoint_amps) - 6'd1))
		else $error("setpoint jumped by more than one");
`endif

endmodule

FILE: rtl/escr_encoder.sv
module escr_encoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  escr_pkg::enc_evt_t             evt,
	input  logic [escr_pkg::SP_BITS-1:0]   limit,
	output logic [escr_pkg::SP_BITS-1:0]   setpoint
);

	logic                         ccw_armed_q;
	logic                         cw_armed_q;
	logic [escr_pkg::SP_BITS-1:0] setpoint_q;
	logic                         ccw_armed_d;
	logic                         cw_armed_d;
	logic [escr_pkg::SP_BITS-1:0] setpoint_d;

	// Arm on the leading edge, step the setpoint once both lines fall
	always_comb begin
		ccw_armed_d = ccw_armed_q;
		cw_armed_d  = cw_armed_q;
		setpoint_d  = setpoint_q;
		if (evt.edge_a) begin
			if (!ccw_armed_q && !evt.line_a && evt.line_b) begin
				ccw_armed_d = 1'b1;
			end
			if (cw_armed_q && !evt.line_a && !evt.line_b) begin
				ccw_armed_d = 1'b0;
				cw_armed_d  = 1'b0;
				if (setpoint_q != '0) begin
					setpoint_d = setpoint_q - 1'b1;
				end
			end
		end else if (evt.edge_b) begin
			if (!cw_armed_q && evt.line_a && !evt.line_b) begin
				cw_armed_d = 1'b1;
			end
			if (ccw_armed_q && !evt.line_a && !evt.line_b) begin
				ccw_armed_d = 1'b0;
				cw_armed_d  = 1'b0;
				if (setpoint_q < limit) begin
					setpoint_d = setpoint_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ccw_armed_q <= 1'b0;
			cw_armed_q  <= 1'b0;
			setpoint_q  <= '0;
		end else begin
			ccw_armed_q <= ccw_armed_d;
			cw_armed_q  <= cw_armed_d;
			setpoint_q  <= setpoint_d;
		end
	end

	assign setpoint = setpoint_q;

endmodule

FILE: rtl/escr_regulator.sv
module escr_regulator #(
	parameter int DAC_BITS = 12,
	parameter int ADC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [escr_pkg::SP_BITS-1:0] setpoint,
	input  logic signed [ADC_BITS-1:0]   sample,
	output logic [DAC_BITS-1:0]          dac_code
);

	// Error width: target below 2^20, scaled sample below 2^(ADC_BITS+4)
	localparam int MAG_BITS = (ADC_BITS + 5 > 21) ? ADC_BITS + 5 : 21;
	localparam int EW = MAG_BITS + 1;
	localparam int SW = DAC_BITS + 3;
	localparam logic signed [EW-1:0] K_TGT = EW'(escr_pkg::TGT_SCALE);
	localparam logic signed [EW-1:0] K_ADC = EW'(escr_pkg::ADC_SCALE);
	localparam logic signed [SW-1:0] CODE_MAX = SW'((1 << DAC_BITS) - 1);

	logic [DAC_BITS-1:0]    code_q;
	logic signed [EW-1:0]   sp_e;
	logic signed [EW-1:0]   smp_e;
	logic signed [EW-1:0]   err;
	logic signed [EW-1:0]   thr [escr_pkg::NUM_BANDS];
	logic signed [SW-1:0]   step;
	logic signed [SW-1:0]   sum;
	logic [DAC_BITS-1:0]    code_d;

	// Form the error in tenths
	assign sp_e  = signed'({{(EW-escr_pkg::SP_BITS){1'b0}}, setpoint});
	assign smp_e = signed'({{(EW-ADC_BITS){sample[ADC_BITS-1]}}, sample});
	assign err   = sp_e * K_TGT - smp_e * K_ADC;

	// Pick the step of the widest band the error exceeds
	always_comb begin
		for (int i = 0; i < escr_pkg::NUM_BANDS; i++) begin
			thr[i] = sp_e * signed'(EW'(escr_pkg::BAND_K[i]));
		end
		if (err > 0) begin
			step = SW'(1);
		end else if (err < 0) begin
			step = -SW'(1);
		end else begin
			step = '0;
		end
		for (int i = escr_pkg::NUM_BANDS - 1; i >= 0; i--) begin
			if (err > thr[i]) begin
				step = signed'(SW'(escr_pkg::BAND_STEP[i]));
			end
		end
	end

	// Apply the step and saturate; zero setpoint parks the code
	always_comb begin
		sum = signed'({3'b000, code_q}) + step;
		if (setpoint == '0 || sum < 0) begin
			code_d = '0;
		end else if (sum > CODE_MAX) begin
			code_d = CODE_MAX[DAC_BITS-1:0];
		end else begin
			code_d = sum[DAC_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= '0;
		end else if (en) begin
			code_q <= code_d;
		end
	end

	assign dac_code = code_q;

endmodule

FILE: tb/escr_checker.sv
module escr_checker #(
	parameter int DAC_BITS = 12,
	parameter int ADC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [1:0]                   func,
	input  logic                         line_a,
	input  logic                         line_b,
	input  logic signed [ADC_BITS-1:0]   sample,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [DAC_BITS-1:0]          dac_code,
	input  logic [escr_pkg::SP_BITS-1:0] setpoint_amps,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [escr_pkg::SP_BITS-1:0] cfg_data,
	output int                           errors,
	output int                           pending,
	output int                           checked,
	output int                           sp_moves,
	output int                           code_full,
	output logic [escr_pkg::SP_BITS-1:0] sp_now
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [DAC_BITS-1:0] CODE_MAX = '1;

	typedef struct packed {
		logic [DAC_BITS-1:0]          code;
		logic [escr_pkg::SP_BITS-1:0] sp;
	} drive_out_t;

	// results owed by the block, oldest first
	drive_out_t owed_q [$];

	// shadow of the regulator state and its limit register
	logic [escr_pkg::SP_BITS-1:0] limit_m;
	logic [escr_pkg::SP_BITS-1:0] sp_m;
	logic                         ccw_m;
	logic                         cw_m;
	logic [DAC_BITS-1:0]          code_m;

	int n_err = 0;
	int n_checked = 0;
	int n_moves = 0;
	int n_full = 0;

	// next DAC code from the banded error between setpoint and scaled sample
	function automatic logic [DAC_BITS-1:0] next_code(
			input logic [escr_pkg::SP_BITS-1:0] sp,
			input logic [DAC_BITS-1:0] code, input logic signed [ADC_BITS-1:0] smp);
		longint band_k [6] = '{8000, 6000, 4000, 3000, 2000, 1000};
		longint band_step [6] = '{300, 170, 120, 60, 40, 30};
		longint spl;
		longint err;
		longint c;
		bit hit;
		spl = longint'(sp);
		// error in tenths: setpoint*1000 against sample*2.2
		err = spl * 10000 - longint'(smp) * 22;
		c = longint'(code);
		hit = 1'b0;
		for (int i = 0; i < 6; i++) begin
			if (!hit && err > spl * band_k[i]) begin
				c += band_step[i];
				hit = 1'b1;
			end
		end
		if (!hit) begin
			if (err > 0)
				c += 1;
			else if (err < 0)
				c -= 1;
		end
		if (spl == 0)
			c = 0;
		if (c < 0)
			c = 0;
		if (c > longint'(CODE_MAX))
			c = longint'(CODE_MAX);
		return c[DAC_BITS-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_out_t want;
		logic [escr_pkg::SP_BITS-1:0] sp_was;
		if (!arst_n) begin
			limit_m = escr_pkg::LIMIT_RST;
			ccw_m = 1'b0;
			cw_m = 1'b0;
			sp_m = '0;
			code_m = '0;
			owed_q.delete();
		end else begin
			// compare the result beat with the oldest owed result
			if (out_valid && !out_stall) begin
				n_checked++;
				if (owed_q.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("%0t: result beat with none owed: code %0d sp %0d",
							$time, dac_code, setpoint_amps);
				end else begin
					want = owed_q.pop_front();
					if (dac_code !== want.code || setpoint_amps !== want.sp) begin
						n_err++;
						if (n_err <= 10)
							$display("%0t: mismatch: expected code %0d sp %0d, %s %0d sp %0d",
								$time, want.code, want.sp, "got code",
								dac_code, setpoint_amps);
					end
				end
			end

			// track the limit register
			if (cfg_valid && cfg_ready)
				limit_m = cfg_data;

			// advance the shadow state on an input beat
			if (in_valid && !in_stall) begin
				sp_was = sp_m;
				case (func)
					escr_pkg::FUNC_EDGE_A: begin
						if (!ccw_m && !line_a && line_b)
							ccw_m = 1'b1;
						if (cw_m && !line_a && !line_b) begin
							cw_m = 1'b0;
							ccw_m = 1'b0;
							if (sp_m != 0)
								sp_m = sp_m - 1'b1;
						end
					end
					escr_pkg::FUNC_EDGE_B: begin
						if (!cw_m && line_a && !line_b)
							cw_m = 1'b1;
						if (ccw_m && !line_a && !line_b) begin
							cw_m = 1'b0;
							ccw_m = 1'b0;
							if (sp_m < limit_m)
								sp_m = sp_m + 1'b1;
						end
					end
					escr_pkg::FUNC_SAMPLE: begin
						code_m = next_code(sp_m, code_m, sample);
						if (code_m == CODE_MAX)
							n_full++;
					end
					default: begin
					end
				endcase
				if (sp_m != sp_was)
					n_moves++;
				want.code = code_m;
				want.sp = sp_m;
				owed_q.push_back(want);
			end
		end
		errors <= n_err;
		pending <= owed_q.size();
		checked <= n_checked;
		sp_moves <= n_moves;
		code_full <= n_full;
		sp_now <= sp_m;
	end

endmodule

FILE: tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DAC_BITS = 12;
	localparam int ADC_BITS = 16;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 240;
	localparam int SMP_MAX = 2 ** (ADC_BITS - 1) - 1;
	localparam int SMP_MIN = -(2 ** (ADC_BITS - 1));
	localparam longint TIMEOUT_NS = 15_000_000;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [1:0]                   func = escr_pkg::FUNC_EDGE_A;
	logic                         line_a = 1'b0;
	logic                         line_b = 1'b0;
	logic signed [ADC_BITS-1:0]   sample = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [DAC_BITS-1:0]          dac_code;
	logic [escr_pkg::SP_BITS-1:0] setpoint_amps;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [escr_pkg::SP_BITS-1:0] cfg_data = '0;

	int                           errors;
	int                           pending;
	int                           checked;
	int                           sp_moves;
	int                           code_full;
	logic [escr_pkg::SP_BITS-1:0] sp_now;

	logic quiet = 1'b0;
	int   items_sent = 0;
	int   hold_cnt = 0;

	encoder_set_current_regulator_unit #(
		.DAC_BITS(DAC_BITS),
		.ADC_BITS(ADC_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.line_a(line_a),
		.line_b(line_b),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dac_code(dac_code),
		.setpoint_amps(setpoint_amps),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	escr_checker #(
		.DAC_BITS(DAC_BITS),
		.ADC_BITS(ADC_BITS)
	) i_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.line_a(line_a),
		.line_b(line_b),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.dac_code(dac_code),
		.setpoint_amps(setpoint_amps),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending),
		.checked(checked),
		.sp_moves(sp_moves),
		.code_full(code_full),
		.sp_now(sp_now)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("tb: done, errors");
		$finish;
	end

	// idle length: mostly short, a few long
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// hold the result side off at random, free-running in quiet stretches
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end else if (quiet || $urandom_range(0, 2) != 0) begin
			out_stall <= 1'b0;
			hold_cnt <= $urandom_range(0, 8);
		end else begin
			out_stall <= 1'b1;
			hold_cnt <= pick_len();
		end
	end

	// present one input beat after a random gap and wait for it to be taken
	task automatic send_item(input logic [1:0] f, input logic a, input logic b,
			input logic signed [ADC_BITS-1:0] s);
		int gap;
		gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : pick_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		line_a <= a;
		line_b <= b;
		sample <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (f != FUNC_UNUSED)
			items_sent++;
	endtask

	// one detent up: arm on line A, complete on line B with both lines low
	task automatic turn_up();
		send_item(escr_pkg::FUNC_EDGE_A, 1'b0, 1'b1, ADC_BITS'($urandom));
		send_item(escr_pkg::FUNC_EDGE_B, 1'b0, 1'b0, ADC_BITS'($urandom));
	endtask

	// one detent down: arm on line B, complete on line A with both lines low
	task automatic turn_down();
		send_item(escr_pkg::FUNC_EDGE_B, 1'b1, 1'b0, ADC_BITS'($urandom));
		send_item(escr_pkg::FUNC_EDGE_A, 1'b0, 1'b0, ADC_BITS'($urandom));
	endtask

	// stop sending until every owed result has arrived
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		logic signed [ADC_BITS-1:0] band_smp [8];
		logic [escr_pkg::SP_BITS-1:0] limits [8];
		int band_k [7];
		int r;
		int s;
		int sp;
		int up_pct;
		int target;

		band_smp = '{16'sd0, 16'sd200, 16'sd400, 16'sd550, 16'sd650, 16'sd800,
			16'sd900, 16'sd1000};
		band_k = '{8000, 6000, 4000, 3000, 2000, 1000, 0};
		limits = '{6'd63, 6'd0, 6'd1, 6'd37, 6'd63, 6'd5, 6'd20, 6'd63};
		limits[6] = escr_pkg::SP_BITS'($urandom_range(2, 62));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero setpoint pins the code at 0, whatever the sample
		send_item(escr_pkg::FUNC_SAMPLE, 1'b0, 1'b0, 16'sh7fff);
		send_item(escr_pkg::FUNC_SAMPLE, 1'b1, 1'b1, 16'sh8000);
		// undefined kind leaves the state as it was
		send_item(FUNC_UNUSED, 1'b1, 1'b1, 16'sh5a5a);
		// one amp: widest band from a zero and the most negative sample, then a step down
		turn_up();
		send_item(escr_pkg::FUNC_SAMPLE, 1'b0, 1'b0, 16'sh0000);
		send_item(escr_pkg::FUNC_SAMPLE, 1'b0, 1'b0, 16'sh8000);
		send_item(escr_pkg::FUNC_SAMPLE, 1'b0, 1'b0, 16'sh7fff);
		// back to zero, and a further step down stays at zero
		turn_down();
		turn_down();
		// two amps: walk the error through every band
		turn_up();
		turn_up();
		foreach (band_smp[i])
			send_item(escr_pkg::FUNC_SAMPLE, 1'b1, 1'b0, band_smp[i]);

		foreach (limits[p]) begin
			// reprogram the limit with the block idle
			drain();
			cfg_valid <= 1'b1;
			cfg_data <= limits[p];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			cfg_valid <= 1'b0;

			up_pct = (limits[p] >= 32) ? 70 : (limits[p] == 0 ? 25 : 50);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				if ($urandom_range(0, 149) == 0)
					quiet <= ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 99) == 0)
					drain();
				r = $urandom_range(0, 99);
				if (r < 55) begin
					if ($urandom_range(0, 99) < up_pct)
						turn_up();
					else
						turn_down();
				end else if (r < 88) begin
					// aim the sample at a band edge or inside the band range
					sp = int'(sp_now);
					r = $urandom_range(0, 99);
					if (sp == 0 || r < 15)
						s = $urandom;
					else if (r < 60)
						s = sp * (10000 - band_k[$urandom_range(0, 6)]) / 22
							+ int'($urandom_range(0, 4)) - 2;
					else
						s = (sp * 10000 - (int'($urandom_range(0, 13000)) - 3000) * sp) / 22;
					if (sp != 0 && r >= 15) begin
						if (s > SMP_MAX)
							s = SMP_MAX;
						if (s < SMP_MIN)
							s = SMP_MIN;
					end
					send_item(escr_pkg::FUNC_SAMPLE, 1'($urandom), 1'($urandom),
						s[ADC_BITS-1:0]);
				end else if (r < 95) begin
					// stray encoder edge with arbitrary line levels
					send_item($urandom_range(0, 1) ? escr_pkg::FUNC_EDGE_B
						: escr_pkg::FUNC_EDGE_A,
						1'($urandom), 1'($urandom), ADC_BITS'($urandom));
				end else begin
					send_item(FUNC_UNUSED, 1'($urandom), 1'($urandom), ADC_BITS'($urandom));
				end
			end
		end

		drain();
		repeat (6) @(posedge clk);

		$display("tb: %0d items over %0d limit settings, %0d results checked",
			items_sent, $size(limits) + 1, checked);
		$display("tb: setpoint moved %0d times, drive code at full scale %0d times",
			sp_moves, code_full);
		if (errors == 0 && pending == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
